// ===== rtl/can_signal_extract_scale_assert.svh =====
// Assertion macros for the CAN signal extract and scale block.
// Expects aclk and aresetn in the scope of each use.
`ifndef CAN_SIGNAL_EXTRACT_SCALE_ASSERT_SVH
`define CAN_SIGNAL_EXTRACT_SCALE_ASSERT_SVH

// same-cycle implication
`define CSE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CSE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cse_pkg.sv =====
// Shared types and constants for the CAN signal extract and scale block.
// No dependencies.
package cse_pkg;

    localparam int CSE_DATA_W        = 64;
    localparam int CSE_LEN_W         = 7;
    localparam int CSE_BYTE_W        = 8;
    localparam int CSE_START_W       = 6;
    localparam int CSE_FACTOR_W      = 32;
    localparam int CSE_OFFSET_W      = 48;
    localparam int CSE_CFG_IDX_W     = 3;
    localparam int CSE_PAYLOAD_BYTES = 8;

    localparam logic [CSE_DATA_W-1:0] CSE_PHYS_MAX = {1'b0, {(CSE_DATA_W-1){1'b1}}};
    localparam logic [CSE_DATA_W-1:0] CSE_PHYS_MIN = {1'b1, {(CSE_DATA_W-1){1'b0}}};

    typedef enum logic [CSE_CFG_IDX_W-1:0] {
        REG_FIRST_POS    = 3'd0,
        REG_BIT_LENGTH   = 3'd1,
        REG_INTEL_ORDER  = 3'd2,
        REG_SIGNED_FIELD = 3'd3,
        REG_SCALE_FACTOR = 3'd4,
        REG_SCALE_OFFSET = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [CSE_START_W-1:0] first_pos;
        logic [CSE_LEN_W-1:0]   bit_length;
        logic                   intel_order;
        logic                   signed_field;
    } field_cfg_t;

    typedef struct packed {
        logic [CSE_DATA_W-1:0] raw;
        logic                  raw_neg;
    } raw_beat_t;

endpackage

// ===== rtl/cse_extract.sv =====
// Field extraction: payload register, position shift, order/sign stage.
// Depends on cse_pkg.
module cse_extract
    import cse_pkg::*;
#(
    parameter int PAYLOAD_BYTES = CSE_PAYLOAD_BYTES
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  field_cfg_t            cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [CSE_DATA_W-1:0] in_payload,
    output logic                  out_valid,
    input  logic                  out_ready,
    output raw_beat_t             out_beat
);

    localparam int PAY_BITS = PAYLOAD_BYTES * CSE_BYTE_W;
    localparam logic [CSE_DATA_W-1:0] PAY_MASK = (PAY_BITS >= CSE_DATA_W) ? '1 :
        ((CSE_DATA_W'(1) << PAY_BITS) - CSE_DATA_W'(1));

    function automatic logic [CSE_DATA_W-1:0] len_mask(input logic [CSE_LEN_W-1:0] len);
        logic [CSE_DATA_W-1:0] m;
        if (len >= CSE_LEN_W'(CSE_DATA_W)) begin
            m = '1;
        end else begin
            m = (CSE_DATA_W'(1) << len) - CSE_DATA_W'(1);
        end
        return m;
    endfunction

    logic                  pay_vld_reg, t_vld_reg, raw_vld_reg;
    logic                  pay_rdy, t_rdy, raw_rdy;
    logic [CSE_DATA_W-1:0] pay_reg;
    logic [CSE_DATA_W-1:0] t_reg, t_next;
    raw_beat_t             raw_reg, raw_next;

    logic [CSE_DATA_W-1:0] d_mot, d_sel, t_rev, raw_mot, raw0;
    logic [CSE_LEN_W-1:0]  len_diff, len_m1;
    logic                  len_ok;

    assign raw_rdy  = !raw_vld_reg || out_ready;
    assign t_rdy    = !t_vld_reg || raw_rdy;
    assign pay_rdy  = !pay_vld_reg || t_rdy;
    assign in_ready = pay_rdy;

    // position shift; Motorola numbering flips bit order within each byte
    always_comb begin
        for (int b = 0; b < CSE_DATA_W / CSE_BYTE_W; b++) begin
            for (int k = 0; k < CSE_BYTE_W; k++) begin
                d_mot[CSE_BYTE_W*b + k] = pay_reg[CSE_BYTE_W*b + CSE_BYTE_W - 1 - k];
            end
        end
        d_sel  = cfg.intel_order ? pay_reg : d_mot;
        t_next = (d_sel >> cfg.first_pos) & len_mask(cfg.bit_length);
    end

    // Motorola field reversal, length check and sign extension
    always_comb begin
        for (int i = 0; i < CSE_DATA_W; i++) begin
            t_rev[i] = t_reg[CSE_DATA_W - 1 - i];
        end
        len_ok   = (cfg.bit_length != '0) && (cfg.bit_length <= CSE_LEN_W'(CSE_DATA_W));
        len_diff = CSE_LEN_W'(CSE_DATA_W) - cfg.bit_length;
        len_m1   = cfg.bit_length - CSE_LEN_W'(1);
        raw_mot  = t_rev >> len_diff[CSE_START_W-1:0];
        raw0     = len_ok ? (cfg.intel_order ? t_reg : raw_mot) : '0;
        raw_next.raw = raw0;
        if (cfg.signed_field && len_ok && (cfg.bit_length < CSE_LEN_W'(CSE_DATA_W)) &&
            raw0[len_m1[CSE_START_W-1:0]]) begin
            raw_next.raw = raw0 | ~len_mask(cfg.bit_length);
        end
        raw_next.raw_neg = cfg.signed_field && raw_next.raw[CSE_DATA_W-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pay_vld_reg <= 1'b0;
            t_vld_reg   <= 1'b0;
            raw_vld_reg <= 1'b0;
        end else begin
            if (pay_rdy) pay_vld_reg <= in_valid;
            if (t_rdy)   t_vld_reg   <= pay_vld_reg;
            if (raw_rdy) raw_vld_reg <= t_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pay_rdy && in_valid)    pay_reg <= in_payload & PAY_MASK;
        if (t_rdy && pay_vld_reg)   t_reg   <= t_next;
        if (raw_rdy && t_vld_reg)   raw_reg <= raw_next;
    end

    assign out_valid = raw_vld_reg;
    assign out_beat  = raw_reg;

endmodule

// ===== rtl/cse_scale.sv =====
// Scaling: split multiply, product merge, offset add with saturation.
// Depends on cse_pkg. Last stage is the result register.
module cse_scale
    import cse_pkg::*;
(
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic signed [CSE_FACTOR_W-1:0] factor,
    input  logic signed [CSE_OFFSET_W-1:0] offset,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  raw_beat_t                      in_beat,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [CSE_DATA_W-1:0]          out_raw,
    output logic [CSE_DATA_W-1:0]          out_phys,
    output logic                           out_sat
);

    localparam int HALF_W = CSE_DATA_W / 2;
    localparam int PP_W   = HALF_W + 1 + CSE_FACTOR_W;
    localparam int PROD_W = PP_W + HALF_W;
    localparam int SUM_W  = PROD_W + 1;

    logic pp_vld_reg, prod_vld_reg, res_vld_reg;
    logic pp_rdy, prod_rdy, res_rdy;

    logic [CSE_DATA_W-1:0]    pp_raw_reg, prod_raw_reg, res_raw_reg;
    logic signed [PP_W-1:0]   pp_lo_reg, pp_lo_next, pp_hi_reg, pp_hi_next;
    logic [PROD_W-1:0]        prod_reg, prod_next;
    logic [SUM_W-1:0]         sum;
    logic [CSE_DATA_W-1:0]    phys_reg, phys_next;
    logic                     sat_reg, sat_next;
    logic [SUM_W-CSE_DATA_W:0] sum_top;

    assign res_rdy  = !res_vld_reg || out_ready;
    assign prod_rdy = !prod_vld_reg || res_rdy;
    assign pp_rdy   = !pp_vld_reg || prod_rdy;
    assign in_ready = pp_rdy;

    // raw taken as a 65-bit signed value, split into two 33 x 32 products
    assign pp_lo_next = $signed({1'b0, in_beat.raw[HALF_W-1:0]}) * factor;
    assign pp_hi_next = $signed({in_beat.raw_neg, in_beat.raw[CSE_DATA_W-1:HALF_W]}) * factor;

    assign prod_next = {pp_hi_reg, {HALF_W{1'b0}}}
                     + {{HALF_W{pp_lo_reg[PP_W-1]}}, pp_lo_reg};

    always_comb begin
        sum = {prod_reg[PROD_W-1], prod_reg}
            + {{(SUM_W-CSE_OFFSET_W){offset[CSE_OFFSET_W-1]}}, offset};
        sum_top  = sum[SUM_W-1:CSE_DATA_W-1];
        sat_next = !((&sum_top) || !(|sum_top));
        if (sat_next) begin
            phys_next = sum[SUM_W-1] ? CSE_PHYS_MIN : CSE_PHYS_MAX;
        end else begin
            phys_next = sum[CSE_DATA_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pp_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
        end else begin
            if (pp_rdy)   pp_vld_reg   <= in_valid;
            if (prod_rdy) prod_vld_reg <= pp_vld_reg;
            if (res_rdy)  res_vld_reg  <= prod_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pp_rdy && in_valid) begin
            pp_lo_reg  <= pp_lo_next;
            pp_hi_reg  <= pp_hi_next;
            pp_raw_reg <= in_beat.raw;
        end
        if (prod_rdy && pp_vld_reg) begin
            prod_reg     <= prod_next;
            prod_raw_reg <= pp_raw_reg;
        end
        if (res_rdy && prod_vld_reg) begin
            phys_reg    <= phys_next;
            sat_reg     <= sat_next;
            res_raw_reg <= prod_raw_reg;
        end
    end

    assign out_valid = res_vld_reg;
    assign out_raw   = res_raw_reg;
    assign out_phys  = phys_reg;
    assign out_sat   = sat_reg;

endmodule

// ===== rtl/can_signal_extract_scale.sv =====
// Top level of the CAN signal extract and scale block: config registers and pipeline.
// Depends on cse_pkg, cse_extract, cse_scale and can_signal_extract_scale_assert.svh.
//
//  channel | direction | content
//  --------+-----------+-----------------------------------------------
//  s_      | in        | payload beat, tdata = payload
//  m_      | out       | result beat, tdata = raw_field, phys_value
//  cfg_    | in        | register write, index and data, always ready
//
//  One beat per cycle sustained while m_ is not stalled; stages in order: payload register,
//  position shift, order/sign, split multiply, product merge, offset/saturate.
//  aresetn synchronous: empties the pipeline and loads register defaults.
//  A stalled m_ beat holds; upstream stages keep filling until all six are full.
`include "can_signal_extract_scale_assert.svh"

module can_signal_extract_scale
    import cse_pkg::*;
#(
    parameter int PAYLOAD_BYTES = CSE_PAYLOAD_BYTES
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [CSE_DATA_W-1:0]    s_tdata,   // [63:0] payload
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [2*CSE_DATA_W-1:0]  m_tdata,   // [63:0] raw_field, [127:64] phys_value
    output logic                     m_tuser,   // [0] saturated
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CSE_CFG_IDX_W-1:0] cfg_index,
    input  logic [CSE_OFFSET_W-1:0]  cfg_data
);

    logic [CSE_START_W-1:0]         first_pos_reg;
    logic [CSE_LEN_W-1:0]           bit_length_reg;
    logic                           intel_order_reg;
    logic                           signed_field_reg;
    logic signed [CSE_FACTOR_W-1:0] scale_factor_reg;
    logic signed [CSE_OFFSET_W-1:0] scale_offset_reg;

    field_cfg_t            field_cfg;
    raw_beat_t             raw_beat;
    logic                  raw_valid, raw_ready;
    logic [CSE_DATA_W-1:0] res_raw, res_phys;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_pos_reg    <= '0;
            bit_length_reg   <= CSE_LEN_W'(CSE_BYTE_W);
            intel_order_reg  <= 1'b1;
            signed_field_reg <= 1'b0;
            scale_factor_reg <= CSE_FACTOR_W'(65536);
            scale_offset_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FIRST_POS:    first_pos_reg    <= cfg_data[CSE_START_W-1:0];
                REG_BIT_LENGTH:   bit_length_reg   <= cfg_data[CSE_LEN_W-1:0];
                REG_INTEL_ORDER:  intel_order_reg  <= cfg_data[0];
                REG_SIGNED_FIELD: signed_field_reg <= cfg_data[0];
                REG_SCALE_FACTOR: scale_factor_reg <= cfg_data[CSE_FACTOR_W-1:0];
                REG_SCALE_OFFSET: scale_offset_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign field_cfg.first_pos    = first_pos_reg;
    assign field_cfg.bit_length   = bit_length_reg;
    assign field_cfg.intel_order  = intel_order_reg;
    assign field_cfg.signed_field = signed_field_reg;

    cse_extract #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_extract (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (field_cfg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_payload (s_tdata),
        .out_valid  (raw_valid),
        .out_ready  (raw_ready),
        .out_beat   (raw_beat)
    );

    cse_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .factor    (scale_factor_reg),
        .offset    (scale_offset_reg),
        .in_valid  (raw_valid),
        .in_ready  (raw_ready),
        .in_beat   (raw_beat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_raw   (res_raw),
        .out_phys  (res_phys),
        .out_sat   (m_tuser)
    );

    assign m_tdata = {res_phys, res_raw};

    // back-pressure on s_ only comes from a stalled result
    `CSE_ASSERT_IMP(a_stall_source, !s_tready, m_tvalid && !m_tready,
        "s_tready low without a stalled result")
    // full pipeline under stall stays full
    `CSE_ASSERT_NXT(a_stall_holds, m_tvalid && !m_tready && !s_tready,
        m_tready || !s_tready, "pipeline drained while output stalled")
    // clipped results sit at a range limit
    `CSE_ASSERT_IMP(a_sat_limit, m_tvalid && m_tuser,
        m_tdata[2*CSE_DATA_W-1:CSE_DATA_W] == CSE_PHYS_MAX ||
        m_tdata[2*CSE_DATA_W-1:CSE_DATA_W] == CSE_PHYS_MIN,
        "saturated beat not at a range limit")
    // zero raw field gives the offset alone, which never clips
    `CSE_ASSERT_IMP(a_zero_no_sat, m_tvalid && (m_tdata[CSE_DATA_W-1:0] == '0),
        !m_tuser, "zero raw field flagged saturated")

endmodule
